// ===== hdl/vrr_pkg.sv =====
package vrr_pkg;

    // Fraction bits of the Qm.F format
    localparam int FRAC_BITS = 28;

    // Width of a floored product (64-bit product shifted right by FRAC_BITS)
    localparam int FW = 64 - FRAC_BITS;

    // Wide signed working width for sums ahead of saturation
    localparam int SW = 66;

    // Square root: radicand is a 31-bit value shifted left by FRAC_BITS
    localparam int SQ_NR = (31 + FRAC_BITS + 1) / 2;
    localparam int SQ_XW = 2 * SQ_NR;

    // Pipeline depth from input transaction to result register
    localparam int LAT = 11 + SQ_NR;

    // Stage numbers that the lanes and the merge stage share
    localparam int ST_KC   = 3;
    localparam int ST_T    = 9;
    localparam int ST_ROOT = ST_T + SQ_NR;

    // Operation codes
    localparam logic FUNC_REFLECT = 1'b0;
    localparam logic FUNC_REFRACT = 1'b1;

    typedef struct packed {
        logic              func;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
        logic signed [31:0] norm_x;
        logic signed [31:0] norm_y;
        logic signed [31:0] norm_z;
        logic [30:0]        eta_ratio;
    } in_data_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic               saturated;
    } out_data_t;

    typedef struct packed {
        logic signed [31:0] val;
        logic               sat;
    } sat_t;

    // Saturate a wide signed value to 32 bits and flag clipping
    function automatic sat_t clip_q(input logic signed [SW-1:0] x);
        logic signed [SW-1:0] max_w;
        logic signed [SW-1:0] min_w;
        sat_t r;
        max_w = {{(SW-31){1'b0}}, {31{1'b1}}};
        min_w = {{(SW-31){1'b1}}, {31{1'b0}}};
        if (x > max_w) begin
            r.val = 32'sh7fffffff;
            r.sat = 1'b1;
        end else if (x < min_w) begin
            r.val = 32'sh80000000;
            r.sat = 1'b1;
        end else begin
            r.val = x[31:0];
            r.sat = 1'b0;
        end
        return r;
    endfunction

endpackage

// ===== hdl/vrr_sqrt.sv =====
module vrr_sqrt (
    input  logic                          aclk,
    input  logic                          ce,
    input  logic [30:0]                   rad,
    output logic [vrr_pkg::SQ_NR-1:0]     root
);

    localparam int NR = vrr_pkg::SQ_NR;
    localparam int XW = vrr_pkg::SQ_XW;

    logic [NR+1:0] rem_w  [0:NR];
    logic [NR-1:0] root_w [0:NR];
    logic [XW-1:0] x_w    [0:NR];

    logic [NR+1:0] rem_reg  [1:NR];
    logic [NR-1:0] root_reg [1:NR];
    logic [XW-1:0] x_reg    [1:NR];

    // Seed the digit recurrence with the scaled radicand
    assign rem_w[0]  = '0;
    assign root_w[0] = '0;
    assign x_w[0]    = XW'({rad, {vrr_pkg::FRAC_BITS{1'b0}}});

    // One root bit per stage
    for (genvar k = 1; k <= NR; k++) begin : g_stage
        logic [NR+1:0] rem_next;
        logic [NR+1:0] trial;
        logic [NR+1:0] rem_next_v;
        logic [NR-1:0] root_next;

        always_comb begin
            rem_next = {rem_w[k-1][NR-1:0], x_w[k-1][XW-1 -: 2]};
            trial    = {root_w[k-1], 2'b01};
            if (rem_next >= trial) begin
                rem_next_v = rem_next - trial;
                root_next  = {root_w[k-1][NR-2:0], 1'b1};
            end else begin
                rem_next_v = rem_next;
                root_next  = {root_w[k-1][NR-2:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                rem_reg[k]  <= rem_next_v;
                root_reg[k] <= root_next;
                x_reg[k]    <= x_w[k-1] << 2;
            end
        end

        assign rem_w[k]  = rem_reg[k];
        assign root_w[k] = root_reg[k];
        assign x_w[k]    = x_reg[k];
    end

    assign root = root_reg[NR];

endmodule

// ===== hdl/vrr_lane.sv =====
module vrr_lane (
    input  logic                            aclk,
    input  logic                            ce,
    input  logic                            func,
    input  logic signed [31:0]              v_in,
    input  logic signed [31:0]              n_in,
    input  logic [30:0]                     eta,
    input  logic signed [31:0]              kc,
    input  logic [vrr_pkg::SQ_NR-1:0]       root,
    output logic signed [vrr_pkg::FW-1:0]   f_out,
    output logic signed [vrr_pkg::FW-1:0]   pp_out,
    output logic signed [31:0]              res,
    output logic                            sat
);

    localparam int F  = vrr_pkg::FRAC_BITS;
    localparam int FW = vrr_pkg::FW;
    localparam int SW = vrr_pkg::SW;
    localparam int L  = vrr_pkg::LAT;

    typedef struct packed {
        logic               func;
        logic signed [31:0] v;
        logic signed [31:0] n;
        logic [30:0]        eta;
        logic signed [31:0] a;
        logic signed [31:0] p;
        logic               flag;
    } lane_carry_t;

    lane_carry_t carry_reg  [1:L-1];
    lane_carry_t carry_next [1:L-1];

    logic signed [63:0]   prod_reg, prod_next;
    logic signed [FW-1:0] f_reg, f_next;
    logic signed [63:0]   m_reg, m_next;
    logic signed [63:0]   e_reg, e_next;
    logic signed [63:0]   pp_reg, pp_next;
    logic signed [63:0]   mr_reg, mr_next;
    logic signed [31:0]   res_reg, res_next;
    logic                 sat_reg, sat_next;

    logic signed [63:0]   neg_prod;
    logic signed [63:0]   sel_prod;
    logic signed [SW-1:0] a_sum;
    logic signed [63:0]   nr_prod;
    vrr_pkg::sat_t        a_clip, p_clip, r_clip;

    // Enter the transaction
    always_comb begin
        carry_next[1].func = func;
        carry_next[1].v    = v_in;
        carry_next[1].n    = n_in;
        carry_next[1].eta  = eta;
        carry_next[1].a    = '0;
        carry_next[1].p    = '0;
        carry_next[1].flag = 1'b0;
    end

    // Stage 1: component product
    assign prod_next = v_in * n_in;

    // Stage 2: floored product, negated for refract
    always_comb begin
        neg_prod = -prod_reg;
        sel_prod = (carry_reg[1].func == vrr_pkg::FUNC_REFRACT) ? neg_prod : prod_reg;
        f_next   = $signed(sel_prod[63:F]);
    end

    // Stage 4: normal times merged scale
    assign m_next = carry_reg[3].n * kc;

    // Stage 5: reflect result or refract sum
    always_comb begin
        if (carry_reg[4].func == vrr_pkg::FUNC_REFRACT) begin
            a_sum = SW'(carry_reg[4].v) + SW'($signed(m_reg[63:F]));
        end else begin
            a_sum = SW'(carry_reg[4].v) - SW'($signed(m_reg[63:F]));
        end
        a_clip = vrr_pkg::clip_q(a_sum);
    end

    // Stage 6: scale by eta
    assign e_next = $signed({1'b0, carry_reg[5].eta}) * carry_reg[5].a;

    // Stage 7: floor and saturate
    assign p_clip = vrr_pkg::clip_q(SW'($signed(e_reg[63:F])));

    // Stage 8: square of the perpendicular component
    assign pp_next = carry_reg[7].p * carry_reg[7].p;

    // Stage after the root: negated normal times root
    always_comb begin
        nr_prod = carry_reg[vrr_pkg::ST_ROOT].n * $signed({1'b0, root});
        mr_next = -nr_prod;
    end

    // Last stage: pick reflect or refract result
    always_comb begin
        r_clip = vrr_pkg::clip_q(SW'(carry_reg[L-1].p) + SW'($signed(mr_reg[63:F])));
        if (carry_reg[L-1].func == vrr_pkg::FUNC_REFRACT) begin
            res_next = r_clip.val;
            sat_next = carry_reg[L-1].flag | r_clip.sat;
        end else begin
            res_next = carry_reg[L-1].a;
            sat_next = carry_reg[L-1].flag;
        end
    end

    // Advance the carried fields, overriding at the stages that compute them
    for (genvar k = 2; k <= L - 1; k++) begin : g_carry
        always_comb begin
            carry_next[k] = carry_reg[k-1];
            if (k == 5) begin
                carry_next[k].a    = a_clip.val;
                carry_next[k].flag = carry_reg[k-1].flag | a_clip.sat;
            end
            if (k == 7) begin
                // The eta product only counts toward the flag for refract
                carry_next[k].p    = p_clip.val;
                carry_next[k].flag = carry_reg[k-1].flag |
                    (p_clip.sat & (carry_reg[k-1].func == vrr_pkg::FUNC_REFRACT));
            end
        end
    end

    for (genvar k = 1; k <= L - 1; k++) begin : g_carry_reg
        always_ff @(posedge aclk) begin
            if (ce) begin
                carry_reg[k] <= carry_next[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            prod_reg <= prod_next;
            f_reg    <= f_next;
            m_reg    <= m_next;
            e_reg    <= e_next;
            pp_reg   <= pp_next;
            mr_reg   <= mr_next;
            res_reg  <= res_next;
            sat_reg  <= sat_next;
        end
    end

    assign f_out  = f_reg;
    assign pp_out = $signed(pp_reg[63:F]);
    assign res    = res_reg;
    assign sat    = sat_reg;

endmodule

// ===== hdl/vrr_merge.sv =====
module vrr_merge (
    input  logic                            aclk,
    input  logic                            ce,
    input  logic                            func,
    input  logic signed [vrr_pkg::FW-1:0]   f0,
    input  logic signed [vrr_pkg::FW-1:0]   f1,
    input  logic signed [vrr_pkg::FW-1:0]   f2,
    input  logic signed [vrr_pkg::FW-1:0]   pp0,
    input  logic signed [vrr_pkg::FW-1:0]   pp1,
    input  logic signed [vrr_pkg::FW-1:0]   pp2,
    output logic signed [31:0]              kc,
    output logic [vrr_pkg::SQ_NR-1:0]       root,
    output logic                            sat
);

    localparam int F  = vrr_pkg::FRAC_BITS;
    localparam int SW = vrr_pkg::SW;
    localparam int L  = vrr_pkg::LAT;
    localparam logic signed [SW-1:0] ONE_W = SW'(1) <<< F;
    localparam logic signed [SW-1:0] MAX_W = {{(SW-31){1'b0}}, {31{1'b1}}};

    logic                 func_reg [1:vrr_pkg::ST_T-1];
    logic signed [31:0]   kc_reg;
    logic [30:0]          t_reg, t_next;
    logic                 flag_reg  [vrr_pkg::ST_KC:L];
    logic                 flag_next [vrr_pkg::ST_KC:L];

    logic signed [SW-1:0] d_sum;
    logic signed [SW-1:0] c_min;
    logic signed [SW-1:0] q_sum;
    logic signed [SW-1:0] t_raw;
    logic                 t_sat;
    vrr_pkg::sat_t        kc_clip;

    // Stage 3: dot product and scale
    always_comb begin
        d_sum = SW'(f0) + SW'(f1) + SW'(f2);
        c_min = (d_sum > ONE_W) ? ONE_W : d_sum;
        if (func_reg[2] == vrr_pkg::FUNC_REFRACT) begin
            kc_clip = vrr_pkg::clip_q(c_min);
        end else begin
            kc_clip = vrr_pkg::clip_q(d_sum <<< 1);
        end
    end

    // Stage 9: magnitude of one minus squared length, flagged only for refract
    always_comb begin
        q_sum = SW'(pp0) + SW'(pp1) + SW'(pp2);
        t_raw = ONE_W - q_sum;
        if (t_raw < 0) begin
            t_raw = -t_raw;
        end
        t_sat = 1'b0;
        if (t_raw > MAX_W) begin
            t_next = '1;
            t_sat  = (func_reg[vrr_pkg::ST_T-1] == vrr_pkg::FUNC_REFRACT);
        end else begin
            t_next = t_raw[30:0];
        end
    end

    // Carry the clip flag down to the result stage
    assign flag_next[vrr_pkg::ST_KC] = kc_clip.sat;
    for (genvar k = vrr_pkg::ST_KC + 1; k <= L; k++) begin : g_flag
        if (k == vrr_pkg::ST_T) begin : g_or
            assign flag_next[k] = flag_reg[k-1] | t_sat;
        end else begin : g_pass
            assign flag_next[k] = flag_reg[k-1];
        end
    end

    for (genvar k = vrr_pkg::ST_KC; k <= L; k++) begin : g_flag_reg
        always_ff @(posedge aclk) begin
            if (ce) begin
                flag_reg[k] <= flag_next[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            func_reg[1] <= func;
            for (int k = 2; k <= vrr_pkg::ST_T - 1; k++) begin
                func_reg[k] <= func_reg[k-1];
            end
            kc_reg      <= kc_clip.val;
            t_reg       <= t_next;
        end
    end

    vrr_sqrt u_sqrt (
        .aclk (aclk),
        .ce   (ce),
        .rad  (t_reg),
        .root (root)
    );

    assign kc  = kc_reg;
    assign sat = flag_reg[L];

endmodule

// ===== hdl/vector_reflect_refract.sv =====
// Channel | Direction | Handshake          | Payload
// s_      | in        | s_valid / s_ready  | s_data (vrr_pkg::in_data_t)
// m_      | out       | m_valid / m_ready  | m_data (vrr_pkg::out_data_t)
//
// One transaction per cycle while no result is held back; each result passes
// through the lane and merge stages and the one-bit-per-stage square root.
// Reset (aresetn low, synchronous) clears only the stage valid bits.
// A result held back by m_ready low freezes the whole pipeline; s_ready follows it.
module vector_reflect_refract (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  vrr_pkg::in_data_t    s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output vrr_pkg::out_data_t   m_data
);

    localparam int L = vrr_pkg::LAT;

    logic [L-1:0] vld_reg, vld_next;
    logic         ce;

    logic signed [31:0] v_in [0:2];
    logic signed [31:0] n_in [0:2];
    logic signed [vrr_pkg::FW-1:0] f_lane  [0:2];
    logic signed [vrr_pkg::FW-1:0] pp_lane [0:2];
    logic signed [31:0] res_lane [0:2];
    logic               sat_lane [0:2];
    logic signed [31:0] kc;
    logic [vrr_pkg::SQ_NR-1:0] root;
    logic               merge_sat;

    // Advance everything when the result register is free or being taken
    assign ce      = !vld_reg[L-1] || m_ready;
    assign s_ready = ce;

    assign vld_next = {vld_reg[L-2:0], s_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ce) begin
            vld_reg <= vld_next;
        end
    end

    assign v_in[0] = s_data.dir_x;
    assign v_in[1] = s_data.dir_y;
    assign v_in[2] = s_data.dir_z;
    assign n_in[0] = s_data.norm_x;
    assign n_in[1] = s_data.norm_y;
    assign n_in[2] = s_data.norm_z;

    // One lane per vector component
    for (genvar i = 0; i < 3; i++) begin : g_lane
        vrr_lane u_lane (
            .aclk   (aclk),
            .ce     (ce),
            .func   (s_data.func),
            .v_in   (v_in[i]),
            .n_in   (n_in[i]),
            .eta    (s_data.eta_ratio),
            .kc     (kc),
            .root   (root),
            .f_out  (f_lane[i]),
            .pp_out (pp_lane[i]),
            .res    (res_lane[i]),
            .sat    (sat_lane[i])
        );
    end

    vrr_merge u_merge (
        .aclk (aclk),
        .ce   (ce),
        .func (s_data.func),
        .f0   (f_lane[0]),
        .f1   (f_lane[1]),
        .f2   (f_lane[2]),
        .pp0  (pp_lane[0]),
        .pp1  (pp_lane[1]),
        .pp2  (pp_lane[2]),
        .kc   (kc),
        .root (root),
        .sat  (merge_sat)
    );

    assign m_valid          = vld_reg[L-1];
    assign m_data.out_x     = res_lane[0];
    assign m_data.out_y     = res_lane[1];
    assign m_data.out_z     = res_lane[2];
    assign m_data.saturated = sat_lane[0] | sat_lane[1] | sat_lane[2] | merge_sat;

    // No new transaction enters while a result is held back
    a_no_accept_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !s_ready)
        else $error("input accepted while output stalled");

    // Pipeline comes out of reset empty
    a_empty_after_reset: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid)
        else $error("result valid right after reset");

    // First stage fills only from an offered input
    a_fill_from_input: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(vld_reg[0]) |-> $past(s_valid))
        else $error("stage one valid without input");

    // A stalled result keeps the stage valid bits of the pipeline frozen
    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(vld_reg))
        else $error("pipeline moved during stall");

endmodule

// ===== sim/vector_reflect_refract_tb.sv =====
`timescale 1ns / 1ps

module vector_reflect_refract_tb;

    localparam logic signed [31:0] Q_ONE  = 32'sh10000000;
    localparam logic signed [31:0] Q_MONE = 32'shf0000000;
    localparam logic signed [31:0] Q_MAX  = 32'sh7fffffff;
    localparam logic signed [31:0] Q_MIN  = 32'sh80000000;
    localparam int RANDOM_ITEMS = 1900;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct {
        vrr_pkg::in_data_t  ray;
        bit                 typed;
        vrr_pkg::out_data_t want;
    } ray_row_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    vrr_pkg::in_data_t  s_data = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    vrr_pkg::out_data_t m_data;

    vrr_pkg::out_data_t ray_expect_q[$];
    ray_row_t  ray_rows[$];
    int        err_cnt = 0;
    int        cycle_cnt = 0;
    bit        long_hold_done = 1'b0;

    vector_reflect_refract u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Stop a hung run
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_cnt, msg);
        err_cnt++;
    endtask

    // Floor of a product scaled back to the format
    function automatic longint fmul(input longint a, input longint b);
        return (a * b) >>> vrr_pkg::FRAC_BITS;
    endfunction

    function automatic longint sat32(input longint x, inout bit flag);
        if (x > 64'sd2147483647) begin
            flag = 1'b1;
            return 64'sd2147483647;
        end
        if (x < -64'sd2147483648) begin
            flag = 1'b1;
            return -64'sd2147483648;
        end
        return x;
    endfunction

    function automatic longint int_sqrt(input longint unsigned x);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return longint'(res);
    endfunction

    // Compute the reflected or refracted direction of one ray
    function automatic vrr_pkg::out_data_t predict_ray(input vrr_pkg::in_data_t ray);
        longint v[3], n[3], o[3], p[3];
        longint eta, d, k, c, q, t, r, s;
        bit flag;
        vrr_pkg::out_data_t res;
        flag = 1'b0;
        v[0] = ray.dir_x;  v[1] = ray.dir_y;  v[2] = ray.dir_z;
        n[0] = ray.norm_x; n[1] = ray.norm_y; n[2] = ray.norm_z;
        eta = longint'({1'b0, ray.eta_ratio});
        if (ray.func == vrr_pkg::FUNC_REFLECT) begin
            d = 0;
            for (int i = 0; i < 3; i++) d += fmul(v[i], n[i]);
            k = sat32(2 * d, flag);
            for (int i = 0; i < 3; i++) o[i] = sat32(v[i] - fmul(k, n[i]), flag);
        end else begin
            c = 0;
            q = 0;
            for (int i = 0; i < 3; i++) c += fmul(-v[i], n[i]);
            if (c > longint'(Q_ONE)) c = Q_ONE;
            c = sat32(c, flag);
            for (int i = 0; i < 3; i++) begin
                s = sat32(v[i] + fmul(n[i], c), flag);
                p[i] = sat32(fmul(eta, s), flag);
                q += fmul(p[i], p[i]);
            end
            t = longint'(Q_ONE) - q;
            if (t < 0) t = -t;
            t = sat32(t, flag);
            r = int_sqrt(longint'(t) << vrr_pkg::FRAC_BITS);
            for (int i = 0; i < 3; i++) o[i] = sat32(p[i] + fmul(-n[i], r), flag);
        end
        res.out_x = o[0][31:0];
        res.out_y = o[1][31:0];
        res.out_z = o[2][31:0];
        res.saturated = flag;
        return res;
    endfunction

    function automatic vrr_pkg::in_data_t mk_ray(input logic f,
        input logic signed [31:0] vx, vy, vz, nx, ny, nz, input logic [30:0] eta);
        vrr_pkg::in_data_t r;
        r.func = f;
        r.dir_x = vx;  r.dir_y = vy;  r.dir_z = vz;
        r.norm_x = nx; r.norm_y = ny; r.norm_z = nz;
        r.eta_ratio = eta;
        return r;
    endfunction

    function automatic logic signed [31:0] rand_comp(input bit wide);
        if (wide) return $urandom;
        return $signed($urandom_range(2 * Q_ONE)) - Q_ONE;
    endfunction

    function automatic vrr_pkg::in_data_t rand_ray();
        bit wide;
        wide = ($urandom_range(9) == 0);
        return mk_ray(1'($urandom_range(1)), rand_comp(wide), rand_comp(wide),
            rand_comp(wide), rand_comp(wide), rand_comp(wide), rand_comp(wide),
            wide ? 31'($urandom) : 31'($urandom_range(32'h20000000)));
    endfunction

    function automatic int rand_gap();
        if ($urandom_range(19) == 0) return $urandom_range(40, 10);
        if ($urandom_range(2) == 0) return 0;
        return $urandom_range(3);
    endfunction

    task automatic add_row(input vrr_pkg::in_data_t ray, input bit typed,
        input vrr_pkg::out_data_t want);
        ray_row_t row;
        row.ray = ray;
        row.typed = typed;
        row.want = want;
        ray_rows.push_back(row);
    endtask

    // Check each result transaction against the oldest expectation
    always @(posedge aclk) begin
        vrr_pkg::out_data_t want;
        if (aresetn && m_valid && m_ready) begin
            if (ray_expect_q.size() == 0) begin
                report_mismatch("result with no expectation");
            end else begin
                want = ray_expect_q.pop_front();
                if (m_data.out_x !== want.out_x)
                    report_mismatch($sformatf("out_x %h want %h", m_data.out_x, want.out_x));
                if (m_data.out_y !== want.out_y)
                    report_mismatch($sformatf("out_y %h want %h", m_data.out_y, want.out_y));
                if (m_data.out_z !== want.out_z)
                    report_mismatch($sformatf("out_z %h want %h", m_data.out_z, want.out_z));
                if (m_data.saturated !== want.saturated)
                    report_mismatch($sformatf("saturated %b want %b",
                        m_data.saturated, want.saturated));
            end
        end
    end

    // Drive result backpressure, with one long hold to fill the pipeline
    initial begin
        int gap;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        repeat (300) @(posedge aclk);
        m_ready <= 1'b0;
        repeat (400) @(posedge aclk);
        long_hold_done = 1'b1;
        forever begin
            m_ready <= 1'b1;
            repeat ($urandom_range(60, 1)) @(posedge aclk);
            gap = rand_gap();
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    end

    initial begin
        int gap;
        int wait_cnt;
        vrr_pkg::out_data_t want;

        // Directed rows; typed expectations only where obvious
        want = '0;
        add_row(mk_ray(vrr_pkg::FUNC_REFLECT, 0, 0, 0, 0, 0, 0, '0), 1'b1, want);
        want.out_x = Q_MONE;
        add_row(mk_ray(vrr_pkg::FUNC_REFLECT, Q_ONE, 0, 0, Q_ONE, 0, 0, '0), 1'b1, want);
        want = '0;
        want.out_z = Q_MONE;
        add_row(mk_ray(vrr_pkg::FUNC_REFRACT, 0, 0, Q_MONE, 0, 0, Q_ONE, 31'(Q_ONE)),
            1'b1, want);
        want = '{Q_MAX, Q_MAX, Q_MAX, 1'b1};
        add_row(mk_ray(vrr_pkg::FUNC_REFLECT, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, '1),
            1'b1, want);
        want = '0;
        add_row(mk_ray(vrr_pkg::FUNC_REFRACT, 0, 0, 0, 0, 0, 0, '0), 1'b0, want);
        add_row(mk_ray(vrr_pkg::FUNC_REFLECT, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, '0),
            1'b0, want);
        add_row(mk_ray(vrr_pkg::FUNC_REFRACT, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, '1),
            1'b0, want);
        add_row(mk_ray(vrr_pkg::FUNC_REFRACT, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, '1),
            1'b0, want);
        add_row(mk_ray(vrr_pkg::FUNC_REFRACT, Q_MAX, Q_MIN, 0, Q_MIN, Q_MAX, 0, '0),
            1'b0, want);
        // total internal reflection: grazing ray, dense to thin
        add_row(mk_ray(vrr_pkg::FUNC_REFRACT, 32'sh0f000000, 0, 32'shfc000000, 0, 0, Q_ONE,
            31'h20000000), 1'b0, want);
        // unnormalized inputs
        add_row(mk_ray(vrr_pkg::FUNC_REFLECT, 32'sh20000000, 32'sh08000000, 0, 0,
            32'sh30000000, 0, '0), 1'b0, want);
        add_row(mk_ray(vrr_pkg::FUNC_REFRACT, 32'sh20000000, 32'shd0000000, Q_ONE, 0,
            32'sh30000000, 32'sh18000000, 31'h18000000), 1'b0, want);
        add_row(mk_ray(vrr_pkg::FUNC_REFRACT, 32'sh0b504f33, 0, 32'shf4afb0cd, 0, 0, Q_ONE,
            31'h0aaaaaab), 1'b0, want);
        add_row(mk_ray(vrr_pkg::FUNC_REFLECT, 32'sh55555555, 32'shaaaaaaaa, 32'sh12345678,
            32'shedcba987, 32'sh0f0f0f0f, 32'shf0f0f0f0, 31'h2aaaaaaa), 1'b0, want);
        for (int i = 0; i < RANDOM_ITEMS; i++)
            add_row(rand_ray(), 1'b0, want);

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Offer each transaction and hold it until accepted
        foreach (ray_rows[i]) begin
            gap = long_hold_done ? rand_gap() : 0;
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            s_valid <= 1'b1;
            s_data <= ray_rows[i].ray;
            do @(posedge aclk); while (!s_ready);
            ray_expect_q.push_back(ray_rows[i].typed ? ray_rows[i].want
                                                     : predict_ray(ray_rows[i].ray));
        end
        s_valid <= 1'b0;

        // Drain, then allow stray results to show up
        while (ray_expect_q.size() != 0) @(posedge aclk);
        wait_cnt = vrr_pkg::LAT + 20;
        repeat (wait_cnt) @(posedge aclk);
        if (err_cnt == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/vrr_pkg.sv
hdl/vrr_sqrt.sv
hdl/vrr_lane.sv
hdl/vrr_merge.sv
hdl/vector_reflect_refract.sv
sim/vector_reflect_refract_tb.sv
